// ===== sv/fdf_pkg.sv =====
// Package for the flooding duplicate filter: sequencer states and
// configuration register indexes. No dependencies.
package fdf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_TRIM,
        ST_WRITE,
        ST_OUT
    } fdf_state_t;

    localparam logic [2:0] REG_OWN_ADDR       = 3'd0;
    localparam logic [2:0] REG_MAX_ENTRIES    = 3'd1;
    localparam logic [2:0] REG_ENTRY_LIFETIME = 3'd2;
    localparam logic [2:0] REG_DEFAULT_TTL    = 3'd3;
    localparam logic [2:0] REG_FLOOD_ENABLE   = 3'd4;

    localparam logic signed [8:0] TTL_USE_DEFAULT = -9'sd1;

endpackage

// ===== sv/flood_duplicate_filter.sv =====
// Flooding network-layer filter with a seen-request cache in a ring memory; uses fdf_pkg.
// A request walks the cache and inserts, skips the insert for a duplicate, records a send
// without a walk, or goes straight to the result; the walk reads one entry per cycle.
// One request at a time: the next is taken after the result has been accepted. Reset
// (aresetn low, synchronous) empties the cache and restores register defaults; memory is
// not cleared.
module flood_duplicate_filter
    import fdf_pkg::*;
#(
    parameter int CACHE_DEPTH = 32,
    parameter int ADDR_BITS   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request in
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // src_addr, dest_addr, seq_num, ttl, now, on_forward_list (lowest first)
    input  logic [((2*ADDR_BITS+74+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                      s_tuser,
    // result out
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // deliver_up, forward, out_ttl, out_seq, duplicate (lowest first)
    output logic [47:0]               m_tdata,
    // configuration writes
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_wdata
);

    localparam int IW  = $clog2(CACHE_DEPTH);
    localparam int CW  = $clog2(CACHE_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int LW  = (CW > 6) ? CW : 6;
    localparam int EW  = ADDR_BITS + 64;
    localparam int INW = ((2*ADDR_BITS+74+7)/8)*8;
    localparam logic [ADDR_BITS-1:0] BCAST = {ADDR_BITS{1'b1}};

    // configuration registers
    logic [15:0] own_addr_reg;
    logic [5:0]  max_entries_reg;
    logic [15:0] entry_lifetime_reg;
    logic [7:0]  default_ttl_reg;
    logic        flood_enable_reg;

    // request fields held for the whole sequence
    logic                  op_reg;
    logic [ADDR_BITS-1:0]  src_reg, src_next;
    logic [ADDR_BITS-1:0]  dst_reg, dst_next;
    logic [31:0]           seq_reg, seq_next;
    logic signed [8:0]     ttl_reg, ttl_next;
    logic [31:0]           now_reg, now_next;
    logic                  listed_reg, listed_next;
    logic                  op_next;

    // cache control
    fdf_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  oldest_reg, oldest_next;
    logic [31:0]    next_seq_reg, next_seq_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]  kept_reg, kept_next;
    logic           pvld_reg, pvld_next;
    logic           stop_reg, stop_next;

    // result register
    logic           m_tvalid_reg, m_tvalid_next;
    logic [47:0]    m_tdata_reg, m_tdata_next;

    // memory
    logic [EW-1:0]  mem [CACHE_DEPTH];
    logic [EW-1:0]  rdata_reg;
    logic           mem_re, mem_we;
    logic [IW-1:0]  mem_raddr, mem_waddr;
    logic [EW-1:0]  mem_wdata;

    logic [CW-1:0]  lim;
    logic [LW-1:0]  lim_w;
    logic [32:0]    exp_sum;
    logic [31:0]    exp_new;
    logic [ADDR_BITS-1:0] own;
    logic           rd_go, expired, match, drop;
    logic [CW-1:0]  excess;
    logic [47:0]    res;

    // ring slot: base + offset, wrapped once
    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base, input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CACHE_DEPTH)) begin
            sum = sum - SW'(CACHE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign own      = ADDR_BITS'(own_addr_reg);

    // effective cache size: zero acts as one, clamp to the memory depth
    always_comb begin
        lim_w = LW'(max_entries_reg);
        if (lim_w == '0) begin
            lim_w = LW'(1);
        end
        if (lim_w > LW'(CACHE_DEPTH)) begin
            lim_w = LW'(CACHE_DEPTH);
        end
        lim = lim_w[CW-1:0];
    end

    // saturating expiry for insert or refresh
    assign exp_sum = {1'b0, now_reg} + 33'(entry_lifetime_reg);
    assign exp_new = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

    // result fields from the held request and the walk outcome
    always_comb begin
        logic up, fwd, dup;
        logic [7:0] ottl;
        logic [31:0] oseq;
        up = 1'b0; fwd = 1'b0; dup = 1'b0; ottl = '0; oseq = '0;
        if (!op_reg) begin
            fwd  = 1'b1;
            ottl = (ttl_reg > 9'sd0) ? ttl_reg[7:0] : 8'd0;
            oseq = seq_reg;
        end else if (ttl_reg <= 9'sd0 && dst_reg == BCAST) begin
            up = 1'b1;
        end else if (stop_reg) begin
            dup = 1'b1;
        end else if (dst_reg == own) begin
            up = 1'b1;
        end else begin
            up = (dst_reg == BCAST);
            if (ttl_reg > 9'sd1 && listed_reg) begin
                fwd  = 1'b1;
                ottl = 8'(ttl_reg - 9'sd1);
                oseq = seq_reg;
            end
        end
        res = {5'd0, dup, oseq, ottl, fwd, up};
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        seq_next      = seq_reg;
        ttl_next      = ttl_reg;
        now_next      = now_reg;
        listed_next   = listed_reg;
        count_next    = count_reg;
        oldest_next   = oldest_reg;
        next_seq_next = next_seq_reg;
        rd_idx_next   = rd_idx_reg;
        kept_next     = kept_reg;
        pvld_next     = 1'b0;
        stop_next     = stop_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_raddr     = ring(oldest_reg, rd_idx_reg);
        mem_waddr     = ring(oldest_reg, kept_reg);
        mem_wdata     = rdata_reg;
        rd_go         = (rd_idx_reg < count_reg);
        expired       = (rdata_reg[31:0] < now_reg);
        drop          = expired && !stop_reg;
        match         = op_reg && !stop_reg && !expired
                        && rdata_reg[EW-1:64] == src_reg && rdata_reg[63:32] == seq_reg;
        excess        = count_reg - lim + CW'(1);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // latch the request; a local send takes the next sequence
                    op_next     = s_tuser;
                    src_next    = s_tdata[ADDR_BITS-1:0];
                    dst_next    = s_tdata[2*ADDR_BITS-1:ADDR_BITS];
                    now_next    = s_tdata[2*ADDR_BITS+72:2*ADDR_BITS+41];
                    listed_next = s_tdata[2*ADDR_BITS+73];
                    stop_next   = 1'b0;
                    ttl_next    = $signed(s_tdata[2*ADDR_BITS+40:2*ADDR_BITS+32]);
                    if (!s_tuser) begin
                        seq_next      = next_seq_reg;
                        next_seq_next = next_seq_reg + 32'd1;
                        if ($signed(s_tdata[2*ADDR_BITS+40:2*ADDR_BITS+32])
                            == TTL_USE_DEFAULT) begin
                            ttl_next = $signed({1'b0, default_ttl_reg});
                        end
                    end else begin
                        seq_next = s_tdata[2*ADDR_BITS+31:2*ADDR_BITS];
                    end
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                rd_idx_next = '0;
                kept_next   = '0;
                if (!op_reg) begin
                    if (flood_enable_reg && ttl_reg > 9'sd0) begin
                        // full cache: drop the first expired entry before insert
                        state_next = (count_reg >= lim) ? ST_SCAN : ST_TRIM;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else if (ttl_reg <= 9'sd0 && dst_reg == BCAST) begin
                    state_next = ST_OUT;
                end else if (flood_enable_reg) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN: begin
                // read one entry per cycle, compact survivors in the following cycle
                if (rd_go) begin
                    mem_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                pvld_next = rd_go;
                if (pvld_reg) begin
                    if (!drop) begin
                        mem_we    = 1'b1;
                        mem_wdata = match ? {src_reg, seq_reg, exp_new} : rdata_reg;
                        kept_next = kept_reg + CW'(1);
                    end else if (!op_reg) begin
                        stop_next = 1'b1;
                    end
                    if (match) begin
                        stop_next = 1'b1;
                    end
                end
                if (!rd_go && !pvld_reg) begin
                    count_next = kept_reg;
                    state_next = (op_reg && stop_reg) ? ST_OUT : ST_TRIM;
                end
            end
            ST_TRIM: begin
                // evict oldest entries until one slot is free
                if (count_reg >= lim) begin
                    oldest_next = ring(oldest_reg, excess);
                    count_next  = lim - CW'(1);
                end
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                mem_waddr  = ring(oldest_reg, count_reg);
                mem_wdata  = {src_reg, seq_reg, exp_new};
                count_next = count_reg + CW'(1);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res;
                end else if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            count_reg          <= '0;
            oldest_reg         <= '0;
            next_seq_reg       <= '0;
            pvld_reg           <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            own_addr_reg       <= 16'd0;
            max_entries_reg    <= 6'd30;
            entry_lifetime_reg <= 16'd3000;
            default_ttl_reg    <= 8'd5;
            flood_enable_reg   <= 1'b1;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            oldest_reg   <= oldest_next;
            next_seq_reg <= next_seq_next;
            pvld_reg     <= pvld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_OWN_ADDR:       own_addr_reg       <= cfg_wdata;
                    REG_MAX_ENTRIES:    max_entries_reg    <= cfg_wdata[5:0];
                    REG_ENTRY_LIFETIME: entry_lifetime_reg <= cfg_wdata;
                    REG_DEFAULT_TTL:    default_ttl_reg    <= cfg_wdata[7:0];
                    REG_FLOOD_ENABLE:   flood_enable_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        seq_reg     <= seq_next;
        ttl_reg     <= ttl_next;
        now_reg     <= now_next;
        listed_reg  <= listed_next;
        rd_idx_reg  <= rd_idx_next;
        kept_reg    <= kept_next;
        stop_reg    <= stop_next;
        m_tdata_reg <= m_tdata_next;
    end

    // cache memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    logic unused_pad;
    assign unused_pad = ^s_tdata[INW-1:2*ADDR_BITS+74];

endmodule
